@@ rtl/core/tdf_pkg.sv @@
`timescale 1ns / 1ps
package tdf_pkg;

	localparam int PV_W        = 16;
	localparam int EXP_W       = 4;
	localparam int OUT_TW      = 24;
	localparam int MAX_RESULTS = 6;
	localparam int NRES_W      = 3;

	localparam logic [1:0] ST_FACTOR = 2'd0;
	localparam logic [1:0] ST_PRIME  = 2'd1;
	localparam logic [1:0] ST_ERROR  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_FETCH,
		S_TEST,
		S_DIV,
		S_EVAL,
		S_FOUND,
		S_FINISH,
		S_ERR
	} state_t;

	typedef struct packed {
		logic ld_num;
		logic init;
		logic load_div;
		logic next_div;
		logic idx_inc;
		logic take_factor;
		logic emit_final;
		logic emit_err;
	} cmd_t;

	typedef struct packed {
		logic seq_ok;
		logic scan_end;
		logic past_half;
		logic div_done;
		logic rem_zero;
		logic e_nz;
		logic pend_v;
		logic res_full;
		logic out_busy;
	} sts_t;

endpackage

@@ rtl/core/tdf_div.sv @@
`timescale 1ns / 1ps
module tdf_div #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  q_q, r_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    rs, diff;
	logic          ge;

	// restoring division, one quotient bit per cycle
	assign rs   = {r_q, q_q[W-1]};
	assign ge   = rs >= {1'b0, d_q};
	assign diff = rs - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[W-2:0], ge};
			r_q <= ge ? diff[W-1:0] : rs[W-1:0];
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;
endmodule

@@ rtl/core/tdf_dp.sv @@
`timescale 1ns / 1ps
module tdf_dp #(
	parameter int NUMBER_WIDTH = 16,
	parameter int PRIME_DEPTH  = 8192
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tdf_pkg::cmd_t                cmd,
	output tdf_pkg::sts_t                sts,
	input  logic [NUMBER_WIDTH-1:0]      in_number,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tdf_pkg::OUT_TW-1:0]   out_data,
	output logic [1:0]                   out_user,
	output logic                         out_last
);
	import tdf_pkg::*;

	localparam int NW = NUMBER_WIDTH;
	localparam int AW = $clog2(PRIME_DEPTH);
	localparam int CW = $clog2(PRIME_DEPTH + 1);

	logic [NW-1:0]    mem [PRIME_DEPTH];
	logic [NW-1:0]    rd_q, number_q, rest_q, p_q, pend_p_q;
	logic [NW:0]      next_q;
	logic [CW-1:0]    count_q, idx_q;
	logic [NRES_W-1:0] nres_q;
	logic [EXP_W-1:0] e_q, pend_e_q;
	logic             pend_v_q, out_v_q;
	logic [OUT_TW-1:0] out_d_q;
	logic [1:0]       out_u_q;
	logic             out_l_q;
	logic             div_start, div_done;
	logic [NW-1:0]    quot, rem;
	logic             store;

	tdf_div #(.W(NW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(cmd.load_div ? number_q : quot),
		.divisor (cmd.load_div ? rd_q : p_q),
		.done    (div_done),
		.quot    (quot),
		.rem     (rem)
	);

	assign div_start = cmd.load_div | cmd.next_div;
	assign store = cmd.emit_final && !pend_v_q && (count_q < CW'(PRIME_DEPTH));

	function automatic logic [PV_W-1:0] to_pv(input logic [NW-1:0] x);
		logic [31:0] ext;
		ext   = 32'(x);
		to_pv = ext[PV_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q[AW-1:0]];
		if (store)
			mem[count_q[AW-1:0]] <= number_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_num)
			number_q <= in_number;
		if (cmd.load_div) begin
			p_q <= rd_q;
			e_q <= '0;
		end else if (cmd.next_div && e_q != '1) begin
			e_q <= e_q + 1'b1;
		end
		if (cmd.take_factor) begin
			pend_p_q <= p_q;
			pend_e_q <= e_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			next_q   <= (NW + 1)'(2);
			idx_q    <= '0;
			nres_q   <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				idx_q    <= '0;
				nres_q   <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.idx_inc)
				idx_q <= idx_q + 1'b1;
			if (cmd.take_factor) begin
				pend_v_q <= 1'b1;
				nres_q   <= nres_q + 1'b1;
			end
			if (store)
				count_q <= count_q + 1'b1;
			if (cmd.emit_final && !next_q[NW])
				next_q <= next_q + 1'b1;
		end
	end

	// one result register on the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (cmd.emit_err || cmd.emit_final || (cmd.take_factor && pend_v_q))
			out_v_q <= 1'b1;
		else if (out_ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			out_d_q <= {4'b0000, EXP_W'(0), PV_W'(0)};
			out_u_q <= ST_ERROR;
			out_l_q <= 1'b1;
		end else if (cmd.take_factor && pend_v_q) begin
			out_d_q <= {4'b0000, pend_e_q, to_pv(pend_p_q)};
			out_u_q <= ST_FACTOR;
			out_l_q <= 1'b0;
		end else if (cmd.emit_final) begin
			if (pend_v_q) begin
				out_d_q <= {4'b0000, pend_e_q, to_pv(pend_p_q)};
				out_u_q <= ST_FACTOR;
			end else begin
				out_d_q <= {4'b0000, EXP_W'(1), to_pv(number_q)};
				out_u_q <= ST_PRIME;
			end
			out_l_q <= 1'b1;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_d_q;
	assign out_user  = out_u_q;
	assign out_last  = out_l_q;

	assign sts.seq_ok    = {1'b0, number_q} == next_q;
	assign sts.scan_end  = idx_q >= count_q;
	assign sts.past_half = rd_q > (number_q >> 1);
	assign sts.div_done  = div_done;
	assign sts.rem_zero  = rem == '0;
	assign sts.e_nz      = e_q != '0;
	assign sts.pend_v    = pend_v_q;
	assign sts.res_full  = nres_q == NRES_W'(MAX_RESULTS - 1);
	assign sts.out_busy  = out_v_q;
endmodule

@@ rtl/core/tdf_ctrl.sv @@
`timescale 1ns / 1ps
module tdf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tdf_pkg::sts_t sts,
	output tdf_pkg::cmd_t cmd
);
	import tdf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_CHECK;
			S_CHECK:  state_d = sts.seq_ok ? S_FETCH : S_ERR;
			S_FETCH:  state_d = sts.scan_end ? S_FINISH : S_TEST;
			S_TEST:   state_d = sts.past_half ? S_FINISH : S_DIV;
			S_DIV:    if (sts.div_done) state_d = S_EVAL;
			S_EVAL: begin
				if (sts.rem_zero)
					state_d = S_DIV;
				else if (sts.e_nz)
					state_d = S_FOUND;
				else
					state_d = S_FETCH;
			end
			S_FOUND: begin
				if (!(sts.pend_v && sts.out_busy))
					state_d = sts.res_full ? S_FINISH : S_FETCH;
			end
			S_FINISH: if (!sts.out_busy) state_d = S_IDLE;
			S_ERR:    if (!sts.out_busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.ld_num = in_valid;
			end
			S_CHECK:  cmd.init = sts.seq_ok;
			S_FETCH:  ;
			S_TEST:   cmd.load_div = !sts.past_half;
			S_DIV:    ;
			S_EVAL: begin
				cmd.next_div = sts.rem_zero;
				cmd.idx_inc  = !sts.rem_zero && !sts.e_nz;
			end
			S_FOUND: begin
				if (!(sts.pend_v && sts.out_busy)) begin
					cmd.take_factor = 1'b1;
					cmd.idx_inc     = !sts.res_full;
				end
			end
			S_FINISH: cmd.emit_final = !sts.out_busy;
			S_ERR:    cmd.emit_err   = !sts.out_busy;
			default:  ;
		endcase
	end
endmodule

@@ rtl/core/trial_division_factorizer.sv @@
`timescale 1ns / 1ps
// With the output idle, an out-of-sequence request passes through CHECK and ERR and is
// answered from the output register; a valid one scans the prime table, dividing on the
// shared bit-serial divider for each prime tried.
// One request at a time, set by the divider and the prime table scan; results leave
// through one output register.
// Reset (arst_n low): no primes stored, next expected number is 2, output empty.
module trial_division_factorizer #(
	parameter int NUMBER_WIDTH = 16,
	parameter int PRIME_DEPTH  = 8192
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]     s_tdata,  // number
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [tdf_pkg::OUT_TW-1:0]            m_tdata,  // prime_value, exponent
	output logic [1:0]                            m_tuser,  // status
	output logic                                  m_tlast
);
	import tdf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tdf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tdf_dp #(
		.NUMBER_WIDTH(NUMBER_WIDTH),
		.PRIME_DEPTH (PRIME_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_number(s_tdata[NUMBER_WIDTH-1:0]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_user (m_tuser),
		.out_last (m_tlast)
	);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_ERROR |-> m_tlast)
		else $error("error result not marked last");

	a_prime_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_PRIME |-> m_tlast && m_tdata[19:16] == EXP_W'(1))
		else $error("malformed prime result");
endmodule

@@ dv/trial_division_factorizer_tb.sv @@
`timescale 1ns / 1ps
module trial_division_factorizer_tb;
	import tdf_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] prime_value;
		logic [3:0]  exponent;
		logic        last;
	} factor_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	logic [15:0] numbers_q[$];
	factor_t     factors_q[$];
	int          primes_found[$];
	int          next_number;
	int          mismatches;
	int          cycles;
	int          accepted;
	int          n_prime, n_factor, n_error;
	int          in_gap, out_gap, hold_cycles;
	bit          hold_done;
	bit          quiet;

	trial_division_factorizer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #4 clk = ~clk;

	// expected results for one accepted number
	task automatic factorize(input logic [15:0] num);
		int      rest, e, half, found;
		factor_t r;
		begin
			found = 0;
			if (num != next_number) begin
				r = '{ST_ERROR, 16'd0, 4'd0, 1'b1};
				factors_q.push_back(r);
				return;
			end
			half = num / 2;
			foreach (primes_found[i]) begin
				if (primes_found[i] > half) break;
				rest = num;
				e = 0;
				while (rest % primes_found[i] == 0) begin
					rest = rest / primes_found[i];
					e++;
				end
				if (e != 0 && found < MAX_RESULTS) begin
					r = '{ST_FACTOR, primes_found[i][15:0], (e > 15) ? 4'd15 : e[3:0], 1'b0};
					factors_q.push_back(r);
					found++;
				end
			end
			if (found == 0) begin
				if (primes_found.size() < 8192) primes_found.push_back(num);
				r = '{ST_PRIME, num, 4'd1, 1'b1};
				factors_q.push_back(r);
			end else begin
				factors_q[factors_q.size()-1].last = 1'b1;
			end
			if (next_number <= 65535) next_number++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			in_gap   <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				factorize(s_tdata);
				accepted++;
			end
			if (s_tvalid && !s_tready) begin
				// hold the offered request
			end else if (in_gap > 0) begin
				in_gap   <= in_gap - 1;
				s_tvalid <= 1'b0;
			end else if (numbers_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				in_gap   <= $urandom_range(0, 5);
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= numbers_q.pop_front();
			end
		end
	end

	// one long output stall, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_done   <= 1'b0;
		end else if (!hold_done && accepted >= 40) begin
			hold_done   <= 1'b1;
			hold_cycles <= 400;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// result monitor and backpressure
	always @(posedge clk or negedge arst_n) begin
		factor_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_gap  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[15:0], m_tdata[19:16], m_tlast};
				case (got.status)
					ST_PRIME:  n_prime++;
					ST_FACTOR: n_factor++;
					default:   n_error++;
				endcase
				if (factors_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: %p", got);
				end else begin
					want = factors_q.pop_front();
					if (got !== want || m_tdata[23:20] !== 4'b0000) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (hold_cycles > 1) begin
				m_tready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap  <= out_gap - 1;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_gap  <= $urandom_range(0, 5);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		quiet <= (numbers_q.size() < 25);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", factors_q.size());
			$display("trial_division_factorizer test failed");
			$finish;
		end
	end

	initial begin
		int seq;
		logic [15:0] v;
		clk = 0;
		arst_n = 0;
		next_number = 2;
		mismatches = 0;
		cycles = 0;
		accepted = 0;
		n_prime = 0;
		n_factor = 0;
		n_error = 0;
		quiet = 0;
		// out of sequence before the first number, range extremes
		numbers_q = '{16'd0, 16'd1, 16'd65535, 16'd3, 16'hAAAA, 16'h5555};
		seq = 2;
		for (int i = 0; i < 18; i++) begin
			numbers_q.push_back(seq[15:0]);
			seq++;
		end
		numbers_q.push_back(16'd2); // repeat of an old number
		for (int i = 0; i < 115; i++) begin
			if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 65535);
			else v = seq[15:0];
			if (v == seq) seq++;
			numbers_q.push_back(v);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1;
		wait (numbers_q.size() == 0 && !s_tvalid && factors_q.size() == 0);
		repeat (200) @(posedge clk);
		$display("%0d numbers taken: %0d primes, %0d factor entries, %0d sequence errors",
			accepted, n_prime, n_factor, n_error);
		$display("numbers reached %0d, with one long output stall", next_number - 1);
		if (mismatches == 0 && factors_q.size() == 0) begin
			$display("trial_division_factorizer test passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("trial_division_factorizer test failed");
		end
		$finish;
	end

endmodule
